[hdl/flog_pkg.sv]
// Shared types and constants for the fault log ring with cursor read.
// Holds the request codes, the stored record layout and default sizes.
// Has no dependencies.
package flog_pkg;

	localparam int DEFAULT_DEPTH = 64;
	localparam int LIMIT_W = 7;

	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_READ   = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	typedef struct packed {
		logic [63:0] seq;
		logic [62:0] time_ns;
		logic [31:0] rule;
		logic [7:0]  code;
		logic [15:0] pc;
		logic [7:0]  opcode;
		logic [31:0] total;
	} rec_t;

endpackage

[hdl/fault_log_ring_with_cursor_read.sv]
// Top level of the fault log ring with cursor read.
// Holds the record memory, the ring pointers and the read sequencer.
// Depends on flog_pkg.
//
// Requests arrive on the req channel (req_valid, req_stall) and results leave
// on the rsp channel (rsp_valid, rsp_stall). An item moves at a rising edge
// where valid is high and stall is low.
// An append or a clear produces no result, so appends can be accepted in
// every cycle while no read is in progress. A read is handled by a small
// sequencer that walks the ring through one memory read port, one entry per
// cycle unless a result is held up by the receiver, using a single 64-bit
// compare to decide whether each entry is newer than the cursor. The oldest
// entry is read as the read is accepted; ST_OLDEST counts the records lost
// before the cursor and ST_CHECK registers a result for each newer entry.
// A read ends at the end of the ring or when the limit is reached. Nothing
// newer than the cursor, an empty ring or a zero limit gives one result
// with no record. The request side is stalled while a read is in progress.
// When the receiver stalls, the current result is held in the output
// register and the scan pauses at the next entry newer than the cursor.
// Reset empties the ring, sets the next sequence number to one and drops any
// read in progress. The record memory itself is not cleared.
module fault_log_ring_with_cursor_read #(
	parameter int DEPTH = flog_pkg::DEFAULT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] rule_id,
	input  logic [7:0]  fault_code,
	input  logic [15:0] fault_pc,
	input  logic [7:0]  fault_opcode,
	input  logic [31:0] fault_total,
	input  logic [62:0] fault_time_ns,
	input  logic [63:0] read_cursor,
	input  logic [6:0]  read_limit,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        has_record,
	output logic [63:0] record_sequence,
	output logic [62:0] record_time_ns,
	output logic [31:0] record_rule,
	output logic [7:0]  record_code,
	output logic [15:0] record_pc,
	output logic [7:0]  record_opcode,
	output logic [31:0] record_fault_total,
	output logic [63:0] new_cursor,
	output logic [63:0] lost_before_cursor,
	output logic        last
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int LIM_W = flog_pkg::LIMIT_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_OLDEST = 2'd1;
	localparam logic [1:0] ST_CHECK  = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	flog_pkg::rec_t mem [DEPTH];
	flog_pkg::rec_t rd_q;
	flog_pkg::rec_t wr_rec;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [OCC_W-1:0] occ_q;
	logic [63:0]      next_seq_q;
	logic             rsp_valid_q;

	logic [63:0]      cursor_q;
	logic [63:0]      wanted_q;
	logic [63:0]      dropped_q;
	logic [LIM_W-1:0] rem_q;
	logic [IDX_W-1:0] left_q;
	logic [IDX_W-1:0] ptr_q;

	logic             has_record_q;
	flog_pkg::rec_t   out_rec_q;
	logic [63:0]      new_cursor_q;
	logic [63:0]      dropped_out_q;
	logic             last_q;

	logic             req_take;
	logic             out_free;
	logic             full;
	logic             is_read;
	logic             go_scan;
	logic             qual;
	logic             at_end;
	logic             is_last;
	logic             emit_rec;
	logic             emit_empty;
	logic             advance;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [LIM_W-1:0] lim_sat;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] res;
		if (idx == IDX_W'(DEPTH - 1)) begin
			res = '0;
		end else begin
			res = idx + 1'b1;
		end
		return res;
	endfunction

	assign req_stall  = (state_q != ST_IDLE);
	assign req_take   = req_valid && !req_stall;
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign full       = (occ_q == OCC_W'(DEPTH));
	assign is_read    = req_take && (req_type == flog_pkg::REQ_READ);
	assign go_scan    = (read_limit != '0) && (occ_q != '0);
	assign lim_sat    = (32'(read_limit) > DEPTH) ? LIM_W'(DEPTH) : read_limit;

	assign qual       = (rd_q.seq >= wanted_q);
	assign at_end     = (left_q == '0);
	assign is_last    = at_end || (rem_q == LIM_W'(1));
	assign emit_rec   = (state_q == ST_CHECK) && qual && out_free;
	assign emit_empty = (state_q == ST_EMPTY) && out_free;
	assign advance    = (state_q == ST_CHECK) && ((emit_rec && !is_last) || (!qual && !at_end));
	assign rd_en      = (is_read && go_scan) || advance;
	assign rd_addr    = (state_q == ST_IDLE) ? head_q : ptr_q;

	assign wr_rec.seq     = next_seq_q;
	assign wr_rec.time_ns = fault_time_ns;
	assign wr_rec.rule    = rule_id;
	assign wr_rec.code    = fault_code;
	assign wr_rec.pc      = fault_pc;
	assign wr_rec.opcode  = fault_opcode;
	assign wr_rec.total   = fault_total;

	always_ff @(posedge clk) begin
		if (req_take && (req_type == flog_pkg::REQ_APPEND)) begin
			mem[tail_q] <= wr_rec;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			next_seq_q  <= 64'd1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (emit_rec || emit_empty) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						case (req_type)
							flog_pkg::REQ_APPEND: begin
								tail_q     <= next_idx(tail_q);
								next_seq_q <= next_seq_q + 64'd1;
								if (full) begin
									head_q <= next_idx(head_q);
								end else begin
									occ_q <= occ_q + 1'b1;
								end
							end
							flog_pkg::REQ_READ: begin
								state_q <= go_scan ? ST_OLDEST : ST_EMPTY;
							end
							flog_pkg::REQ_CLEAR: begin
								head_q     <= '0;
								tail_q     <= '0;
								occ_q      <= '0;
								next_seq_q <= 64'd1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_OLDEST: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (emit_rec && is_last) begin
						state_q <= ST_IDLE;
					end else if (!qual && at_end) begin
						state_q <= ST_EMPTY;
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (is_read) begin
			cursor_q <= read_cursor;
			wanted_q <= read_cursor + 64'd1;
			rem_q    <= lim_sat;
			left_q   <= IDX_W'(occ_q - 1'b1);
			ptr_q    <= next_idx(head_q);
		end
		if (state_q == ST_OLDEST) begin
			if (qual) begin
				dropped_q <= rd_q.seq - wanted_q;
				wanted_q  <= rd_q.seq;
			end else begin
				dropped_q <= '0;
			end
		end
		if (advance) begin
			ptr_q  <= next_idx(ptr_q);
			left_q <= left_q - 1'b1;
		end
		if (emit_rec) begin
			rem_q         <= rem_q - 1'b1;
			has_record_q  <= 1'b1;
			out_rec_q     <= rd_q;
			new_cursor_q  <= rd_q.seq;
			dropped_out_q <= dropped_q;
			last_q        <= is_last;
		end else if (emit_empty) begin
			has_record_q  <= 1'b0;
			out_rec_q     <= '0;
			new_cursor_q  <= cursor_q;
			dropped_out_q <= '0;
			last_q        <= 1'b1;
		end
	end

	assign rsp_valid          = rsp_valid_q;
	assign has_record         = has_record_q;
	assign record_sequence    = out_rec_q.seq;
	assign record_time_ns     = out_rec_q.time_ns;
	assign record_rule        = out_rec_q.rule;
	assign record_code        = out_rec_q.code;
	assign record_pc          = out_rec_q.pc;
	assign record_opcode      = out_rec_q.opcode;
	assign record_fault_total = out_rec_q.total;
	assign new_cursor         = new_cursor_q;
	assign lost_before_cursor = dropped_out_q;
	assign last               = last_q;

endmodule
